// File: hw/rtl/sacht_pkg.sv
// shared types and constants for the set-associative cache hit tracker
package sacht_pkg;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  localparam logic MODE_LRU  = 1'b0;
  localparam logic MODE_FIFO = 1'b1;

  localparam int ADDR_W     = 32;
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int OUT_WAY_W  = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_REPLACE_MODE = 1'b0;

endpackage

// File: hw/rtl/sacht_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module sacht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/set_assoc_cache_hit_tracker.sv
// top level of the set-associative cache hit tracker
//
// in channel: one fetch address per transaction (in_valid / in_ready)
// out channel: hit flag, way used and running hit and miss counts per transaction
// cfg channel: apb-style port, register 0 holds replace_mode (0 lru, 1 fifo)
// each set is one ram row holding valid bits, tags, use stamps and the fifo
// pointer; a transaction reads its row, decides, then writes the row back
// the result is registered after the lookup state, and for an lru miss on a full
// set after the scan state, where the stamps are scanned one way per cycle
// one transaction is in work at a time, and no new one is taken before the last
// result is loaded; in_ready is high only while no transaction is in work
// the output register frees the input side once the result is loaded
// reset clears the mode, counters, stamp clock and a per-set written flag;
// a row never written reads as all zero, so no clearing pass is needed
// when the receiver stalls, the finished result waits in the output register
// and a following transaction holds before write-back until it is taken
module set_assoc_cache_hit_tracker #(
  parameter int NUM_SETS   = 8,
  parameter int NUM_WAYS   = 4,
  parameter int LINE_BYTES = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sacht_pkg::ADDR_W-1:0]        in_fetch_address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_was_hit,
  output logic [sacht_pkg::OUT_WAY_W-1:0]     out_way_used,
  output logic [sacht_pkg::CNT_W-1:0]         out_hits_so_far,
  output logic [sacht_pkg::CNT_W-1:0]         out_misses_so_far,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [sacht_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [sacht_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [sacht_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  function automatic int flog2(input int v);
    int r;
    int x;
    r = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      r = r + 1;
    end
    return r;
  endfunction

  localparam int OFS     = flog2(LINE_BYTES);
  localparam int IDX     = flog2(NUM_SETS);
  localparam int SET_W   = (IDX > 0) ? IDX : 1;
  localparam int TAG_W   = sacht_pkg::ADDR_W - OFS - IDX;
  localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int STAMP_W = sacht_pkg::STAMP_W;
  localparam int V_LO    = 0;
  localparam int T_LO    = NUM_WAYS;
  localparam int S_LO    = T_LO + NUM_WAYS * TAG_W;
  localparam int P_LO    = S_LO + NUM_WAYS * STAMP_W;
  localparam int ROW_W   = P_LO + WAY_W;

  localparam logic [SET_W-1:0] SET_MASK = SET_W'((64'd1 << IDX) - 64'd1);
  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NUM_WAYS - 1);

  sacht_pkg::state_t state_r, state_nxt;

  logic                          mode_r;
  logic [sacht_pkg::ADDR_W-1:0]  addr_r;
  logic [SET_W-1:0]              set_r;
  logic                          hit_r, hit_nxt;
  logic [WAY_W-1:0]              way_r, way_nxt;
  logic [WAY_W-1:0]              scan_idx_r, scan_idx_nxt;
  logic [STAMP_W-1:0]            best_r, best_nxt;
  logic [STAMP_W-1:0]            stamp_clk_r;
  logic [sacht_pkg::CNT_W-1:0]   hit_cnt_r, miss_cnt_r;
  logic [NUM_SETS-1:0]           row_written_r;

  logic                          out_valid_r;
  logic                          out_was_hit_r;
  logic [sacht_pkg::OUT_WAY_W-1:0] out_way_r;
  logic [sacht_pkg::CNT_W-1:0]   out_hits_r, out_misses_r;

  logic                          in_fire;
  logic                          done_fire;
  logic [SET_W-1:0]              in_set;
  logic [TAG_W-1:0]              cur_tag;
  logic [ROW_W-1:0]              rd_row;
  logic [ROW_W-1:0]              row_cur;
  logic [ROW_W-1:0]              row_nxt;
  logic                          any_hit, any_inv;
  logic [WAY_W-1:0]              hit_way, inv_way, fifo_way, ptr_cur, ptr_nxt;
  logic [STAMP_W-1:0]            scan_stamp;
  logic [STAMP_W-1:0]            stamp_clk_inc;
  logic                          cfg_wr;

  assign in_ready  = (state_r == sacht_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_set    = SET_W'(in_fetch_address >> OFS) & SET_MASK;
  assign cur_tag   = TAG_W'(addr_r >> (OFS + IDX));
  assign done_fire = (state_r == sacht_pkg::S_DONE) && (!out_valid_r || out_ready);
  assign row_cur   = row_written_r[set_r] ? rd_row : '0;
  assign ptr_cur   = row_cur[P_LO +: WAY_W];
  assign fifo_way  = (ptr_cur > LAST_WAY) ? '0 : ptr_cur;
  assign ptr_nxt   = (way_r == LAST_WAY) ? '0 : way_r + WAY_W'(1);
  assign scan_stamp    = row_cur[S_LO + scan_idx_r * STAMP_W +: STAMP_W];
  assign stamp_clk_inc = stamp_clk_r + STAMP_W'(1);

  sacht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (done_fire),
    .wr_addr (set_r),
    .wr_data (row_nxt),
    .rd_en   (in_fire),
    .rd_addr (in_set),
    .rd_data (rd_row)
  );

  // tag compare and first invalid way, lowest way wins
  always_comb begin
    any_hit = 1'b0;
    any_inv = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row_cur[V_LO + w] && (row_cur[T_LO + w * TAG_W +: TAG_W] == cur_tag)) begin
        any_hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!row_cur[V_LO + w]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    hit_nxt      = hit_r;
    way_nxt      = way_r;
    scan_idx_nxt = scan_idx_r;
    best_nxt     = best_r;
    unique case (state_r)
      sacht_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = sacht_pkg::S_LOOK;
        end
      end
      sacht_pkg::S_LOOK: begin
        hit_nxt = any_hit;
        priority if (any_hit) begin
          way_nxt   = hit_way;
          state_nxt = sacht_pkg::S_DONE;
        end else if (mode_r == sacht_pkg::MODE_FIFO) begin
          way_nxt   = fifo_way;
          state_nxt = sacht_pkg::S_DONE;
        end else if (any_inv) begin
          way_nxt   = inv_way;
          state_nxt = sacht_pkg::S_DONE;
        end else begin
          way_nxt      = '0;
          best_nxt     = '1;
          scan_idx_nxt = '0;
          state_nxt    = sacht_pkg::S_SCAN;
        end
      end
      sacht_pkg::S_SCAN: begin
        if (scan_stamp < best_r) begin
          best_nxt = scan_stamp;
          way_nxt  = scan_idx_r;
        end
        scan_idx_nxt = scan_idx_r + WAY_W'(1);
        if (scan_idx_r == LAST_WAY) begin
          state_nxt = sacht_pkg::S_DONE;
        end
      end
      sacht_pkg::S_DONE: begin
        if (done_fire) begin
          state_nxt = sacht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sacht_pkg::S_IDLE;
      end
    endcase
  end

  // row write-back
  always_comb begin
    row_nxt = row_cur;
    if (mode_r == sacht_pkg::MODE_LRU) begin
      row_nxt[S_LO + way_r * STAMP_W +: STAMP_W] = stamp_clk_inc;
    end
    if (!hit_r) begin
      row_nxt[V_LO + way_r]               = 1'b1;
      row_nxt[T_LO + way_r * TAG_W +: TAG_W] = cur_tag;
      if (mode_r == sacht_pkg::MODE_FIFO) begin
        row_nxt[P_LO +: WAY_W] = ptr_nxt;
      end
    end
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == sacht_pkg::REG_REPLACE_MODE)
                      ? sacht_pkg::CFG_DATA_W'(mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sacht_pkg::S_IDLE;
      mode_r        <= sacht_pkg::MODE_LRU;
      stamp_clk_r   <= '0;
      hit_cnt_r     <= '0;
      miss_cnt_r    <= '0;
      row_written_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && (cfg_paddr[2] == sacht_pkg::REG_REPLACE_MODE)) begin
        mode_r <= cfg_pwdata[0];
      end
      if (out_valid_r && out_ready && !done_fire) begin
        out_valid_r <= 1'b0;
      end
      if (done_fire) begin
        out_valid_r          <= 1'b1;
        row_written_r[set_r] <= 1'b1;
        if (mode_r == sacht_pkg::MODE_LRU) begin
          stamp_clk_r <= stamp_clk_inc;
        end
        if (hit_r) begin
          hit_cnt_r <= hit_cnt_r + sacht_pkg::CNT_W'(1);
        end else begin
          miss_cnt_r <= miss_cnt_r + sacht_pkg::CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hit_r      <= hit_nxt;
    way_r      <= way_nxt;
    scan_idx_r <= scan_idx_nxt;
    best_r     <= best_nxt;
    if (in_fire) begin
      addr_r <= in_fetch_address;
      set_r  <= in_set;
    end
    if (done_fire) begin
      out_was_hit_r <= hit_r;
      out_way_r     <= sacht_pkg::OUT_WAY_W'(way_r);
      out_hits_r    <= hit_r ? hit_cnt_r + sacht_pkg::CNT_W'(1) : hit_cnt_r;
      out_misses_r  <= hit_r ? miss_cnt_r : miss_cnt_r + sacht_pkg::CNT_W'(1);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_was_hit       = out_was_hit_r;
  assign out_way_used      = out_way_r;
  assign out_hits_so_far   = out_hits_r;
  assign out_misses_so_far = out_misses_r;

endmodule

// File: sim/sacht_hit_checker.sv
// checker for the cache hit tracker: predicts each lookup and compares the results
module sacht_hit_checker #(
  parameter int NUM_SETS   = 8,
  parameter int NUM_WAYS   = 4,
  parameter int LINE_BYTES = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [sacht_pkg::ADDR_W-1:0]        in_fetch_address,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_was_hit,
  input  logic [sacht_pkg::OUT_WAY_W-1:0]     out_way_used,
  input  logic [sacht_pkg::CNT_W-1:0]         out_hits_so_far,
  input  logic [sacht_pkg::CNT_W-1:0]         out_misses_so_far,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [sacht_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [sacht_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  input  logic [sacht_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  input  logic                                cfg_pready,
  output int                                  outstanding,
  output int                                  fail_count
);

  localparam int OFS_W = $clog2(LINE_BYTES);
  localparam int IDX_W = $clog2(NUM_SETS);
  localparam int TAG_W = sacht_pkg::ADDR_W - OFS_W - IDX_W;
  localparam logic [sacht_pkg::CFG_ADDR_W-1:0] MODE_ADDR =
    sacht_pkg::CFG_ADDR_W'(4 * sacht_pkg::REG_REPLACE_MODE);
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic                              hit;
    logic [sacht_pkg::OUT_WAY_W-1:0]   way;
    logic [sacht_pkg::CNT_W-1:0]       hits;
    logic [sacht_pkg::CNT_W-1:0]       misses;
  } lookup_result_t;

  logic                            mode;
  logic [TAG_W-1:0]                line_tag   [NUM_SETS][NUM_WAYS];
  logic                            line_valid [NUM_SETS][NUM_WAYS];
  logic [sacht_pkg::STAMP_W-1:0]   line_stamp [NUM_SETS][NUM_WAYS];
  int unsigned                     rr_ptr     [NUM_SETS];
  logic [sacht_pkg::STAMP_W-1:0]   stamp_clock;
  logic [sacht_pkg::CNT_W-1:0]     hit_cnt;
  logic [sacht_pkg::CNT_W-1:0]     miss_cnt;
  lookup_result_t                  expected_lookups[$];
  int                              failures = 0;
  int                              reported = 0;

  function automatic lookup_result_t predict_lookup(input logic [sacht_pkg::ADDR_W-1:0] addr);
    int unsigned                   set_idx;
    int unsigned                   way;
    logic [TAG_W-1:0]              tag;
    logic                          hit;
    logic                          found_free;
    logic [sacht_pkg::STAMP_W-1:0] best;
    lookup_result_t                r;
    set_idx = int'(addr[OFS_W +: IDX_W]);
    tag     = addr[sacht_pkg::ADDR_W-1 -: TAG_W];
    hit     = 1'b0;
    way     = 0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
        hit = 1'b1;
        way = w;
      end
    end
    if (hit) begin
      hit_cnt++;
      if (mode == sacht_pkg::MODE_LRU) begin
        stamp_clock++;
        line_stamp[set_idx][way] = stamp_clock;
      end
    end else begin
      miss_cnt++;
      if (mode == sacht_pkg::MODE_LRU) begin
        best       = '1;
        found_free = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (!found_free) begin
            if (!line_valid[set_idx][w]) begin
              way        = w;
              found_free = 1'b1;
            end else if (line_stamp[set_idx][w] < best) begin
              best = line_stamp[set_idx][w];
              way  = w;
            end
          end
        end
        stamp_clock++;
        line_stamp[set_idx][way] = stamp_clock;
      end else begin
        way = rr_ptr[set_idx];
        rr_ptr[set_idx] = (way + 1 >= NUM_WAYS) ? 0 : way + 1;
      end
      line_tag[set_idx][way]   = tag;
      line_valid[set_idx][way] = 1'b1;
    end
    r.hit    = hit;
    r.way    = sacht_pkg::OUT_WAY_W'(way);
    r.hits   = hit_cnt;
    r.misses = miss_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (!rst_n) begin
      mode        = sacht_pkg::MODE_LRU;
      stamp_clock = '0;
      hit_cnt     = '0;
      miss_cnt    = '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        rr_ptr[s] = 0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          line_tag[s][w]   = '0;
          line_valid[s][w] = 1'b0;
          line_stamp[s][w] = '0;
        end
      end
      expected_lookups.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr == MODE_ADDR) mode = cfg_pwdata[0];
        end else if (cfg_paddr == MODE_ADDR &&
                     cfg_prdata !== sacht_pkg::CFG_DATA_W'(mode)) begin
          failures++;
          if (reported < REPORT_MAX) begin
            reported++;
            $display("replace_mode read: expected %0d got %h", mode, cfg_prdata);
          end
        end
      end
      if (out_valid && out_ready) begin
        got = '{out_was_hit, out_way_used, out_hits_so_far, out_misses_so_far};
        if (expected_lookups.size() == 0) begin
          failures++;
          if (reported < REPORT_MAX) begin
            reported++;
            $display("unexpected transaction: hit=%0d way=%0d hits=%0d misses=%0d",
                     got.hit, got.way, got.hits, got.misses);
          end
        end else begin
          want = expected_lookups.pop_front();
          if (got !== want) begin
            failures++;
            if (reported < REPORT_MAX) begin
              reported++;
              $display("lookup mismatch: expected hit=%0d way=%0d hits=%0d misses=%0d",
                       want.hit, want.way, want.hits, want.misses);
              $display("                 got      hit=%0d way=%0d hits=%0d misses=%0d",
                       got.hit, got.way, got.hits, got.misses);
            end
          end
        end
      end
      if (in_valid && in_ready) expected_lookups.push_back(predict_lookup(in_fetch_address));
    end
    outstanding <= expected_lookups.size();
    fail_count  <= failures;
  end

endmodule

// File: sim/set_assoc_cache_hit_tracker_tb.sv
// testbench top for the cache hit tracker: clock, reset, stimulus and verdict
module set_assoc_cache_hit_tracker_tb;

  localparam int NUM_SETS   = 8;
  localparam int NUM_WAYS   = 4;
  localparam int LINE_BYTES = 4;
  localparam int OFS_W      = $clog2(LINE_BYTES);
  localparam int IDX_W      = $clog2(NUM_SETS);
  localparam int TAG_W      = sacht_pkg::ADDR_W - OFS_W - IDX_W;
  localparam int POOL_SIZE  = 6;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 150;
  localparam int HOLD_AT    = 320;
  localparam int HOLD_LEN   = 150;
  localparam int CALM_FROM  = 500;
  localparam int CALM_TO    = 650;
  localparam int RUN_LIMIT  = 400000;
  localparam logic [sacht_pkg::CFG_ADDR_W-1:0] MODE_ADDR =
    sacht_pkg::CFG_ADDR_W'(4 * sacht_pkg::REG_REPLACE_MODE);
  localparam logic [sacht_pkg::CFG_ADDR_W-1:0] SPARE_ADDR = sacht_pkg::CFG_ADDR_W'(4);

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [sacht_pkg::ADDR_W-1:0]       in_fetch_address = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic                               out_was_hit;
  logic [sacht_pkg::OUT_WAY_W-1:0]    out_way_used;
  logic [sacht_pkg::CNT_W-1:0]        out_hits_so_far;
  logic [sacht_pkg::CNT_W-1:0]        out_misses_so_far;
  logic                               cfg_psel = 1'b0;
  logic                               cfg_penable = 1'b0;
  logic                               cfg_pwrite = 1'b0;
  logic [sacht_pkg::CFG_ADDR_W-1:0]   cfg_paddr = '0;
  logic [sacht_pkg::CFG_DATA_W-1:0]   cfg_pwdata = '0;
  logic [sacht_pkg::CFG_DATA_W-1:0]   cfg_prdata;
  logic                               cfg_pready;
  int                                 outstanding;
  int                                 fail_count;
  int                                 items_sent = 0;
  int                                 hold_left = 0;
  bit                                 hold_done = 1'b0;
  int unsigned                        cycle_cnt = 0;
  logic [TAG_W-1:0]                   tag_pool[POOL_SIZE];

  set_assoc_cache_hit_tracker #(
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .LINE_BYTES (LINE_BYTES)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_fetch_address  (in_fetch_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_was_hit       (out_was_hit),
    .out_way_used      (out_way_used),
    .out_hits_so_far   (out_hits_so_far),
    .out_misses_so_far (out_misses_so_far),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  sacht_hit_checker #(
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .LINE_BYTES (LINE_BYTES)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_fetch_address  (in_fetch_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_was_hit       (out_was_hit),
    .out_way_used      (out_way_used),
    .out_hits_so_far   (out_hits_so_far),
    .out_misses_so_far (out_misses_so_far),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .outstanding       (outstanding),
    .fail_count        (fail_count)
  );

  initial begin
    forever begin
      #6 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, one calm stretch
  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (items_sent >= CALM_FROM && items_sent < CALM_TO) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 24);
      end
    end
  end

  function automatic logic [sacht_pkg::ADDR_W-1:0] fetch_addr(input logic [TAG_W-1:0] tag,
                                                              input int unsigned set_idx);
    return {tag, IDX_W'(set_idx), OFS_W'($urandom_range(LINE_BYTES - 1))};
  endfunction

  task automatic send_fetch(input logic [sacht_pkg::ADDR_W-1:0] addr);
    in_valid         <= 1'b1;
    in_fetch_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (!(items_sent >= CALM_FROM && items_sent < CALM_TO)) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [sacht_pkg::CFG_ADDR_W-1:0] addr,
                            input logic [sacht_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic mode);
    cfg_access(1'b1, MODE_ADDR, {(sacht_pkg::CFG_DATA_W - 1)'($urandom), mode});
    cfg_access(1'b0, MODE_ADDR, '0);
  endtask

  initial begin
    int                           r;
    logic                         phase_mode;
    logic [sacht_pkg::ADDR_W-1:0] addr;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(sacht_pkg::MODE_LRU);

    // lru: address extremes, offset-only differences, eviction of the oldest stamp
    send_fetch(32'h0000_0000);
    send_fetch(32'hFFFF_FFFF);
    send_fetch(32'h0000_0003);
    send_fetch(32'hFFFF_FFFC);
    send_fetch(fetch_addr(TAG_W'('h11), 1));
    send_fetch(fetch_addr(TAG_W'('h22), 1));
    send_fetch(fetch_addr(TAG_W'('h33), 1));
    send_fetch(fetch_addr(TAG_W'('h44), 1));
    send_fetch(fetch_addr(TAG_W'('h11), 1));
    send_fetch(fetch_addr(TAG_W'('h55), 1));
    send_fetch(fetch_addr(TAG_W'('h33), 1));
    send_fetch(fetch_addr(TAG_W'('h66), 1));
    wait_drained();

    // fifo: pointer way refilled even while invalid ways remain
    set_mode(sacht_pkg::MODE_FIFO);
    send_fetch(fetch_addr(TAG_W'('h77), 1));
    send_fetch(fetch_addr(TAG_W'('h12), 0));
    send_fetch(fetch_addr(TAG_W'('h13), 0));
    send_fetch(fetch_addr(TAG_W'('h33), 1));
    for (int k = 1; k <= NUM_WAYS; k++) send_fetch(fetch_addr(TAG_W'(k), 3));
    wait_drained();

    // back to lru with all stamps equal, spare register write must be ignored
    set_mode(sacht_pkg::MODE_LRU);
    cfg_access(1'b1, SPARE_ADDR, {(sacht_pkg::CFG_DATA_W - 1)'($urandom), sacht_pkg::MODE_FIFO});
    cfg_access(1'b0, MODE_ADDR, '0);
    send_fetch(fetch_addr(TAG_W'('h5), 3));
    send_fetch(fetch_addr(TAG_W'('h2), 3));

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      phase_mode = (p % 2 == 0) ? sacht_pkg::MODE_FIFO : sacht_pkg::MODE_LRU;
      set_mode(phase_mode);
      for (int k = 0; k < POOL_SIZE; k++) tag_pool[k] = TAG_W'($urandom);
      for (int i = 0; i < PHASE_LEN; i++) begin
        r = $urandom_range(99);
        if (r < 80) begin
          addr = fetch_addr(tag_pool[$urandom_range(POOL_SIZE - 1)], $urandom_range(NUM_SETS - 1));
        end else if (r < 90) begin
          addr = fetch_addr($urandom_range(1) ? {TAG_W{1'b1}} : {TAG_W{1'b0}},
                            $urandom_range(NUM_SETS - 1));
        end else begin
          addr = $urandom;
        end
        send_fetch(addr);
      end
    end

    wait_drained();
    repeat (2 * (3 + NUM_WAYS)) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
